/* design/positional_array_insert_delete_search_macros.svh */
// assertion helpers shared by the design files
`ifndef POSITIONAL_ARRAY_INSERT_DELETE_SEARCH_MACROS_SVH
`define POSITIONAL_ARRAY_INSERT_DELETE_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
`define PAIDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PAIDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PAIDS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PAIDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/paids_pkg.sv */
package paids_pkg;

    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 8;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK_UP,
        S_WALK_DN,
        S_DRAIN,
        S_PUT,
        S_DONE
    } t_state;

    // what an accepted item needs
    typedef enum logic [1:0] {
        PL_NONE,
        PL_APPEND,
        PL_SHIFT,
        PL_WALK
    } t_plan;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic put;
        logic finish;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_plan plan;
        logic  last;
        logic  hit_now;
        logic  is_insert;
        logic  out_free;
    } t_stat;

endpackage

/* design/paids_ram.sv */
module paids_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/paids_ctrl.sv */
`include "positional_array_insert_delete_search_macros.svh"

module paids_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  paids_pkg::t_stat i_stat,
    output paids_pkg::t_cmd  o_cmd,
    output logic             o_stall
);

    paids_pkg::t_state r_state;
    paids_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= paids_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            paids_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_stat.plan)
                        paids_pkg::PL_NONE:   n_state = paids_pkg::S_DONE;
                        paids_pkg::PL_APPEND: n_state = paids_pkg::S_PUT;
                        paids_pkg::PL_SHIFT:  n_state = paids_pkg::S_WALK_DN;
                        paids_pkg::PL_WALK:   n_state = paids_pkg::S_WALK_UP;
                        default:              n_state = paids_pkg::S_DONE;
                    endcase
                end
            end
            paids_pkg::S_WALK_UP: begin
                if (i_stat.hit_now) begin
                    n_state = paids_pkg::S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    if (i_stat.last) begin
                        n_state = paids_pkg::S_DRAIN;
                    end
                end
            end
            paids_pkg::S_WALK_DN: begin
                o_cmd.rd_en = 1'b1;
                if (i_stat.last) begin
                    n_state = paids_pkg::S_DRAIN;
                end
            end
            paids_pkg::S_DRAIN: begin
                o_cmd.finish = 1'b1;
                n_state = i_stat.is_insert ? paids_pkg::S_PUT : paids_pkg::S_DONE;
            end
            paids_pkg::S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = paids_pkg::S_DONE;
            end
            paids_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = paids_pkg::S_IDLE;
                end
            end
            default: n_state = paids_pkg::S_IDLE;
        endcase
    end

    assign o_stall = (r_state != paids_pkg::S_IDLE);

    `PAIDS_ASSERT_IMPL(a_walk_dn_is_insert, i_clk, i_rst_n, r_state == paids_pkg::S_WALK_DN, i_stat.is_insert)
    `PAIDS_ASSERT_NEXT(a_put_then_done, i_clk, i_rst_n, r_state == paids_pkg::S_PUT, r_state == paids_pkg::S_DONE)

endmodule

/* design/paids_dp.sv */
`include "positional_array_insert_delete_search_macros.svh"

module paids_dp #(
    parameter int CAPACITY = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  paids_pkg::t_cmd                     i_cmd,
    output paids_pkg::t_stat                    o_stat,
    input  logic [1:0]                          i_operation,
    input  logic [paids_pkg::POS_W-1:0]         i_position,
    input  logic signed [paids_pkg::VAL_W-1:0]  i_value,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic [paids_pkg::STAT_W-1:0]        o_status,
    output logic signed [paids_pkg::VAL_W-1:0]  o_data_out,
    output logic [paids_pkg::POS_W-1:0]         o_found_index,
    output logic [paids_pkg::CNT_W-1:0]         o_entry_count
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int MW  = (CW > paids_pkg::POS_W) ? CW : paids_pkg::POS_W;
    localparam int XW  = MW + 1;
    localparam int VW  = paids_pkg::VAL_W;

    logic [1:0]                   r_op;
    logic [AW-1:0]                r_pos;
    logic [VW-1:0]                r_val;
    logic [AW-1:0]                r_addr;
    logic                         r_rvld;
    logic [AW-1:0]                r_qaddr;
    logic [paids_pkg::STAT_W-1:0] r_status;
    logic [VW-1:0]                r_data;
    logic [AW-1:0]                r_found;
    logic                         r_hit;
    logic [CW-1:0]                r_count;
    logic                         r_ovalid;
    logic [paids_pkg::STAT_W-1:0] r_ostatus;
    logic [VW-1:0]                r_odata;
    logic [paids_pkg::POS_W-1:0]  r_ofound;
    logic [paids_pkg::CNT_W-1:0]  r_ocount;

    logic [XW-1:0]                pos_x;
    logic [XW-1:0]                cnt_x;
    logic [XW-1:0]                addr_x;
    logic [XW-1:0]                found_x;
    logic [AW-1:0]                pos_a;
    logic                         full;
    logic                         empty;
    paids_pkg::t_plan             plan;
    logic [paids_pkg::STAT_W-1:0] code;
    logic [AW-1:0]                start_addr;
    logic                         last;
    logic                         hit_now;

    logic [VW-1:0]                w_rdata;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [VW-1:0]                w_wdata;

    assign pos_x   = {{(XW - paids_pkg::POS_W){1'b0}}, i_position};
    assign cnt_x   = {{(XW - CW){1'b0}}, r_count};
    assign addr_x  = {{(XW - AW){1'b0}}, r_addr};
    assign found_x = {{(XW - AW){1'b0}}, r_found};
    assign pos_a   = pos_x[AW-1:0];
    assign full    = (r_count == CW'(CAPACITY));
    assign empty   = (r_count == '0);

    // classify the incoming item against the current count
    always_comb begin
        plan       = paids_pkg::PL_NONE;
        code       = paids_pkg::ST_OK;
        start_addr = pos_a;
        if (i_operation == paids_pkg::OP_INSERT) begin
            start_addr = AW'(cnt_x - XW'(1));
            if (full) begin
                code = paids_pkg::ST_FULL;
            end else if (pos_x > cnt_x) begin
                code = paids_pkg::ST_BADPOS;
            end else if (pos_x == cnt_x) begin
                plan = paids_pkg::PL_APPEND;
            end else begin
                plan = paids_pkg::PL_SHIFT;
            end
        end else if (empty) begin
            code = paids_pkg::ST_EMPTY;
        end else if (i_operation == paids_pkg::OP_SEARCH) begin
            plan       = paids_pkg::PL_WALK;
            code       = paids_pkg::ST_NOTFOUND;
            start_addr = '0;
        end else if (pos_x >= cnt_x) begin
            code = paids_pkg::ST_BADPOS;
        end else begin
            plan = paids_pkg::PL_WALK;
        end
    end

    // final read of the walk
    always_comb begin
        unique case (r_op)
            paids_pkg::OP_INSERT: last = (r_addr == r_pos);
            paids_pkg::OP_DELETE,
            paids_pkg::OP_SEARCH: last = ((addr_x + XW'(1)) == cnt_x);
            paids_pkg::OP_READ:   last = 1'b1;
            default:              last = 1'b1;
        endcase
    end

    assign hit_now = r_rvld && (r_op == paids_pkg::OP_SEARCH) && !r_hit && (w_rdata == r_val);

    // write port: final insert write, or shifted entries coming back from the read port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_qaddr + AW'(1);
        w_wdata = w_rdata;
        if (i_cmd.put) begin
            w_we    = 1'b1;
            w_waddr = r_pos;
            w_wdata = r_val;
        end else if (r_rvld && (r_op == paids_pkg::OP_INSERT)) begin
            w_we = 1'b1;
        end else if (r_rvld && (r_op == paids_pkg::OP_DELETE) && (r_qaddr != r_pos)) begin
            w_we    = 1'b1;
            w_waddr = r_qaddr - AW'(1);
        end
    end

    paids_ram #(
        .WIDTH (VW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvld   <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_rvld <= i_cmd.rd_en;
            if (i_cmd.put) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.finish && (r_op == paids_pkg::OP_DELETE)) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_operation;
            r_pos    <= pos_a;
            r_val    <= i_value;
            r_addr   <= start_addr;
            r_status <= code;
            r_data   <= '0;
            r_found  <= '0;
            r_hit    <= 1'b0;
        end else begin
            if (i_cmd.rd_en) begin
                r_addr <= (r_op == paids_pkg::OP_INSERT) ? r_addr - AW'(1) : r_addr + AW'(1);
            end
            if (r_rvld) begin
                case (r_op)
                    paids_pkg::OP_DELETE: begin
                        if (r_qaddr == r_pos) begin
                            r_data <= w_rdata;
                        end
                    end
                    paids_pkg::OP_READ: r_data <= w_rdata;
                    paids_pkg::OP_SEARCH: begin
                        if (hit_now) begin
                            r_hit    <= 1'b1;
                            r_found  <= r_qaddr;
                            r_status <= paids_pkg::ST_OK;
                        end
                    end
                    default: ;
                endcase
            end
        end
        r_qaddr <= r_addr;
        if (i_cmd.load_out) begin
            r_ostatus <= r_status;
            r_odata   <= r_data;
            r_ofound  <= found_x[paids_pkg::POS_W-1:0];
            r_ocount  <= cnt_x[paids_pkg::CNT_W-1:0];
        end
    end

    assign o_stat.plan      = plan;
    assign o_stat.last      = last;
    assign o_stat.hit_now   = hit_now;
    assign o_stat.is_insert = (r_op == paids_pkg::OP_INSERT);
    assign o_stat.out_free  = !r_ovalid || !i_stall;

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_data_out    = r_odata;
    assign o_found_index = r_ofound;
    assign o_entry_count = r_ocount;

    `PAIDS_ASSERT_IMPL(a_no_write_clash, i_clk, i_rst_n, i_cmd.put, !r_rvld)
    `PAIDS_ASSERT_IMPL(a_count_in_range, i_clk, i_rst_n, r_ovalid || !r_ovalid, r_count <= CW'(CAPACITY))
    `PAIDS_ASSERT_NEXT(a_hit_stops_walk, i_clk, i_rst_n, hit_now, !r_rvld)

endmodule

/* design/positional_array_insert_delete_search.sv */
// channel  direction  handshake          payload
// input    in         i_valid / o_stall  i_operation, i_position, i_value
// output   out        o_valid / i_stall  o_status, o_data_out, o_found_index, o_entry_count
//
// one item at a time; entries live in a single-port-read, single-port-write ram
// insert: the downward shift walk moves entries up from the tail, then puts; append only puts
// delete walks up from the position, search up to its first match, read does one ram read
// synchronous active-low reset clears the count and the output valid; ram is not cleared
// a result held by i_stall lets the next item in, but that item's result waits for it
module positional_array_insert_delete_search #(
    parameter int CAPACITY = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input transfer
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_operation,
    input  logic [paids_pkg::POS_W-1:0]         i_position,
    input  logic signed [paids_pkg::VAL_W-1:0]  i_value,
    // output transfer
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [paids_pkg::STAT_W-1:0]        o_status,
    output logic signed [paids_pkg::VAL_W-1:0]  o_data_out,
    output logic [paids_pkg::POS_W-1:0]         o_found_index,
    output logic [paids_pkg::CNT_W-1:0]         o_entry_count
);

    // command and status between sequencer and datapath
    paids_pkg::t_cmd  cmd;
    paids_pkg::t_stat stat;

    // sequencer: walks the ram one address a cycle
    paids_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    // datapath: count, pointers, ram, compare and output register
    paids_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_value       (i_value),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_found_index (o_found_index),
        .o_entry_count (o_entry_count)
    );

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH = 128;

    // one result as the block reports it
    typedef struct {
        logic [paids_pkg::STAT_W-1:0]       status;
        logic signed [paids_pkg::VAL_W-1:0] data;
        logic [paids_pkg::POS_W-1:0]        index;
        logic [paids_pkg::CNT_W-1:0]        count;
    } t_result;

    // shadow copy of the array plus the queue of results still owed by the block
    class array_scoreboard;
        logic signed [paids_pkg::VAL_W-1:0] stored[DEPTH];
        int                                 fill;
        t_result                            owed[$];
        int                                 faults;

        function new();
            fill   = 0;
            faults = 0;
        endfunction

        // apply one operation to the shadow array, return what the block must answer
        function t_result apply_operation(logic [1:0] op, logic [paids_pkg::POS_W-1:0] pos,
                                          logic signed [paids_pkg::VAL_W-1:0] val);
            t_result res;
            int      i;
            res.status = paids_pkg::ST_OK;
            res.data   = '0;
            res.index  = '0;
            if (op == paids_pkg::OP_INSERT) begin
                if (fill >= DEPTH) begin
                    res.status = paids_pkg::ST_FULL;
                end else if (int'(pos) > fill) begin
                    res.status = paids_pkg::ST_BADPOS;
                end else begin
                    for (i = fill; i > int'(pos); i--)
                        stored[i] = stored[i-1];
                    stored[pos] = val;
                    fill++;
                end
            end else if (fill == 0) begin
                res.status = paids_pkg::ST_EMPTY;
            end else if (op == paids_pkg::OP_SEARCH) begin
                res.status = paids_pkg::ST_NOTFOUND;
                for (i = 0; i < fill; i++) begin
                    if (stored[i] == val) begin
                        res.status = paids_pkg::ST_OK;
                        res.index  = i[paids_pkg::POS_W-1:0];
                        break;
                    end
                end
            end else if (int'(pos) >= fill) begin
                res.status = paids_pkg::ST_BADPOS;
            end else begin
                res.data = stored[pos];
                if (op == paids_pkg::OP_DELETE) begin
                    for (i = int'(pos); i + 1 < fill; i++)
                        stored[i] = stored[i+1];
                    fill--;
                end
            end
            res.count = fill[paids_pkg::CNT_W-1:0];
            return res;
        endfunction

        function void note_request(logic [1:0] op, logic [paids_pkg::POS_W-1:0] pos,
                                   logic signed [paids_pkg::VAL_W-1:0] val);
            owed.push_back(apply_operation(op, pos, val));
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("%0t: unexpected result status=%0d data=%0d index=%0d count=%0d",
                             $realtime, got.status, got.data, got.index, got.count);
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status || got.data !== want.data ||
                got.index !== want.index || got.count !== want.count) begin
                faults++;
                if (faults <= 10)
                    $display("%0t: mismatch exp status=%0d data=%0d index=%0d count=%0d, %s",
                             $realtime, want.status, want.data, want.index, want.count,
                             $sformatf("got status=%0d data=%0d index=%0d count=%0d",
                                       got.status, got.data, got.index, got.count));
            end
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_stall;
    logic [1:0]                         i_operation;
    logic [paids_pkg::POS_W-1:0]        i_position;
    logic signed [paids_pkg::VAL_W-1:0] i_value;
    logic                               o_valid;
    logic                               i_stall;
    logic [paids_pkg::STAT_W-1:0]       o_status;
    logic signed [paids_pkg::VAL_W-1:0] o_data_out;
    logic [paids_pkg::POS_W-1:0]        o_found_index;
    logic [paids_pkg::CNT_W-1:0]        o_entry_count;

    array_scoreboard sb = new();

    // items left in a stretch where the sender never pauses
    int unsigned steady_left = 0;

    positional_array_insert_delete_search #(
        .CAPACITY(DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_data_out   (o_data_out),
        .o_found_index(o_found_index),
        .o_entry_count(o_entry_count)
    );

    // 8 ns clock, low first
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // hard stop in case the block hangs
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // sender pause before an item: mostly none or short, now and then long,
    // with occasional stretches of back-to-back transfers
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady_left > 0) begin
            steady_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            steady_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // present one item and hold it until the block takes it
    task automatic send(logic [1:0] op, logic [paids_pkg::POS_W-1:0] pos,
                        logic signed [paids_pkg::VAL_W-1:0] val);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_value     <= val;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        // transfer done at this edge
        sb.note_request(op, pos, val);
    endtask

    // directed opening: empty array, both ends of the value range, duplicates,
    // first-match search, miss, positions at and past the end
    task automatic run_directed();
        send(paids_pkg::OP_SEARCH, 7'd0,   32'sd5);            // empty search
        send(paids_pkg::OP_DELETE, 7'd0,   32'sd0);            // empty delete
        send(paids_pkg::OP_READ,   7'd127, 32'sd0);            // empty read
        send(paids_pkg::OP_INSERT, 7'd1,   32'sd9);            // insert past the end
        send(paids_pkg::OP_INSERT, 7'd0,   32'sh8000_0000);
        send(paids_pkg::OP_INSERT, 7'd1,   32'sh7fff_ffff);
        send(paids_pkg::OP_INSERT, 7'd0,   32'sd0);            // shift everything up
        send(paids_pkg::OP_INSERT, 7'd1,   -32'sd1);
        send(paids_pkg::OP_INSERT, 7'd4,   32'sh7fff_ffff);    // append a duplicate
        send(paids_pkg::OP_INSERT, 7'd127, 32'sd3);            // far past the end
        send(paids_pkg::OP_SEARCH, 7'd0,   32'sh7fff_ffff);    // must report the first copy
        send(paids_pkg::OP_SEARCH, 7'd127, 32'sd0);
        send(paids_pkg::OP_SEARCH, 7'd0,   32'sd12345);        // miss
        send(paids_pkg::OP_READ,   7'd4,   32'sd0);            // last entry
        send(paids_pkg::OP_READ,   7'd5,   32'sd0);            // one past the end
        send(paids_pkg::OP_READ,   7'd127, 32'sd0);
        send(paids_pkg::OP_DELETE, 7'd5,   32'sd0);            // delete past the end
        send(paids_pkg::OP_DELETE, 7'd0,   32'sd0);            // delete at the head
        send(paids_pkg::OP_DELETE, 7'd3,   32'sd0);            // delete the tail
        send(paids_pkg::OP_DELETE, 7'd1,   32'sd0);
        send(paids_pkg::OP_SEARCH, 7'd0,   32'sh5555_aaaa);
    endtask

    // random part: alternate between filling toward full and draining toward
    // empty so both ends and deep shifts are reached; a share of positions
    // lands out of range and searches mostly target stored values
    task automatic run_random(int unsigned n);
        bit                                 growing;
        int unsigned                        hold;
        int unsigned                        r;
        int                                 pos;
        logic [1:0]                         op;
        logic signed [paids_pkg::VAL_W-1:0] val;
        growing = 1'b1;
        hold    = 0;
        repeat (n) begin
            if (growing && sb.fill == DEPTH) begin
                hold++;
                if (hold > 10) begin
                    growing = 1'b0;
                    hold    = 0;
                end
            end else if (!growing && sb.fill == 0) begin
                hold++;
                if (hold > 3) begin
                    growing = 1'b1;
                    hold    = 0;
                end
            end

            r = $urandom_range(0, 99);
            if (growing)
                op = (r < 70) ? paids_pkg::OP_INSERT :
                     (r < 80) ? paids_pkg::OP_DELETE :
                     (r < 90) ? paids_pkg::OP_SEARCH : paids_pkg::OP_READ;
            else
                op = (r < 15) ? paids_pkg::OP_INSERT :
                     (r < 70) ? paids_pkg::OP_DELETE :
                     (r < 85) ? paids_pkg::OP_SEARCH : paids_pkg::OP_READ;

            r = $urandom_range(0, 99);
            if (r < 12)
                pos = $urandom_range(0, 127);
            else if (r < 16)
                pos = sb.fill + 1;
            else if (op == paids_pkg::OP_INSERT)
                pos = (r < 40) ? sb.fill : $urandom_range(0, sb.fill);
            else
                pos = (sb.fill == 0) ? 0 : $urandom_range(0, sb.fill - 1);
            if (pos > 127)
                pos = 127;

            r = $urandom_range(0, 99);
            if (op == paids_pkg::OP_SEARCH && sb.fill > 0 && r < 70)
                val = sb.stored[$urandom_range(0, sb.fill - 1)];
            else if (r < 85)
                val = $urandom;
            else if (r < 95)
                val = $signed($urandom_range(0, 7)) - 32'sd4;   // small pool, forces duplicates
            else
                val = r[0] ? 32'sh8000_0000 : 32'sh7fff_ffff;

            send(op, pos[paids_pkg::POS_W-1:0], val);
        end
    endtask

    // receiver stall: short bursts, a few long holds, and quiet stretches
    initial begin
        int unsigned r;
        int unsigned busy;
        int unsigned free;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                busy = 0;
                free = $urandom_range(20, 80);
            end else begin
                busy = (r < 85) ? $urandom_range(1, 3) : $urandom_range(15, 40);
                free = $urandom_range(1, 4);
            end
            if (busy > 0) begin
                i_stall <= 1'b1;
                repeat (busy) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat (free) @(posedge i_clk);
        end
    end

    // result monitor: a transfer happens where valid is high and stall is low
    always @(posedge i_clk) begin
        t_result got;
        got.status = o_status;
        got.data   = o_data_out;
        got.index  = o_found_index;
        got.count  = o_entry_count;
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(got);
    end

    // main sequence
    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_operation <= paids_pkg::OP_INSERT;
        i_position  <= '0;
        i_value     <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(1030);
        i_valid <= 1'b0;

        // drain everything still owed, then give the block time to misbehave
        while (sb.owed.size() > 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        if (sb.faults == 0 && sb.owed.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/paids_pkg.sv
design/paids_ram.sv
design/paids_ctrl.sv
design/paids_dp.sv
design/positional_array_insert_delete_search.sv
verif/tb.sv
